// ===== rtl/msc_pkg.sv =====
// shared types and constants of the multichannel sample calibrator
// no dependencies

package msc_pkg;

    localparam int MAX_CHANNELS_DEF = 256;

    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 8;
    localparam int GROUND_W  = 16;
    localparam int SPAN_W    = 17;
    localparam int CNT_W     = 9;
    localparam int RESULT_W  = 49;
    localparam int FRAC_BITS = 16;
    // |(raw - ground) * phys_span| stays below 2^32
    localparam int PROD_MAG_W = 32;
    localparam int DIVIDEND_W = PROD_MAG_W + FRAC_BITS;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CAL    = 1'b1;

    typedef struct packed {
        logic [GROUND_W-1:0]      ground;
        logic [SPAN_W-1:0]        logic_span;
        logic signed [SPAN_W-1:0] phys_span;
    } t_cal_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV
    } t_state;

endpackage

// ===== rtl/multichannel_sample_calibrator_unit.sv =====
// path from input transfer to result valid: table read register, product register,
// divider start, bit-serial division, then the output register, held while the output stalls
// input is stalled until the result is loaded into the output register, so no new sample is taken before then; a
// calibration transfer is accepted only while idle and gives no result
// reset: synchronous active low; clears position, channel count to 1 and handshake
// state; calibration tables hold garbage until written
// depends on msc_pkg, msc_cal_mem, msc_div

module multichannel_sample_calibrator_unit import msc_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CNT_W-1:0]            i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [SAMPLE_W-1:0]         i_sample_word,
    input  logic [CHAN_W-1:0]           i_chan_index,
    input  logic [GROUND_W-1:0]         i_cal_ground,
    input  logic [SPAN_W-1:0]           i_cal_logic_span,
    input  logic signed [SPAN_W-1:0]    i_cal_phys_span,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [RESULT_W-1:0]  o_scaled_value,
    output logic [CHAN_W-1:0]           o_out_channel,
    output logic                        o_frame_last
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_CHANNELS);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_pos, n_pos;

    // input side
    logic in_xfer, smp_xfer, cal_xfer, cal_in_range;
    logic [CW-1:0] count_eff, pos_ext, pos_inc;
    logic          last;
    logic [AW-1:0] wr_addr;
    t_cal_entry    wr_entry, rd_entry;

    // per-item working registers
    logic [SAMPLE_W-1:0]   r_raw;
    logic [CHAN_W-1:0]     r_chan;
    logic                  r_last;
    logic [PROD_MAG_W-1:0] r_mag;
    logic                  r_neg;
    logic [SPAN_W-1:0]     r_span;
    logic                  r_span_zero;

    logic signed [SPAN_W-1:0]     diff;
    logic signed [2*SPAN_W-1:0]   prod;
    logic [2*SPAN_W-1:0]          prod_abs;

    // fsm outputs
    logic rd_en, load_prod, div_start, out_load;

    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [RESULT_W-1:0]   q_ext, q_signed;

    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_scaled;
    logic [CHAN_W-1:0]          r_out_chan;
    logic                       r_out_last;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign smp_xfer = in_xfer && (i_req_type == REQ_SAMPLE);
    assign cal_xfer = in_xfer && (i_req_type == REQ_CAL);

    assign cal_in_range = CW'(i_chan_index) < MAX_CW;

    generate
        if (AW >= CHAN_W) begin : g_addr_wide
            assign wr_addr = AW'(i_chan_index);
        end else begin : g_addr_narrow
            assign wr_addr = i_chan_index[AW-1:0];
        end
    endgenerate

    assign wr_entry = '{ground: i_cal_ground, logic_span: i_cal_logic_span,
                        phys_span: i_cal_phys_span};

    // frame position tracking
    always_comb begin
        if (r_count == '0) begin
            count_eff = CW'(1);
        end else if (CW'(r_count) > MAX_CW) begin
            count_eff = MAX_CW;
        end else begin
            count_eff = CW'(r_count);
        end
        pos_ext = CW'(r_pos);
        pos_inc = pos_ext + CW'(1);
        last    = pos_inc >= count_eff;
        n_pos   = last ? '0 : pos_inc[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (smp_xfer) begin
            r_pos <= n_pos;
        end
    end

    // a calibration write lands at its transfer edge, so a later sample read sees it
    msc_cal_mem #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (cal_xfer && cal_in_range),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (smp_xfer) begin
            r_raw  <= i_sample_word;
            r_chan <= pos_ext[CHAN_W-1:0];
            r_last <= last;
        end
    end

    always_comb begin
        diff     = $signed({1'b0, r_raw}) - $signed({1'b0, rd_entry.ground});
        prod     = diff * rd_entry.phys_span;
        prod_abs = prod[2*SPAN_W-1] ? (2*SPAN_W)'(-prod) : prod;
    end

    always_ff @(posedge i_clk) begin
        if (load_prod) begin
            r_mag       <= prod_abs[PROD_MAG_W-1:0];
            r_neg       <= prod[2*SPAN_W-1];
            r_span      <= rd_entry.logic_span;
            r_span_zero <= rd_entry.logic_span == '0;
        end
    end

    msc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_mag, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (smp_xfer) n_state = S_READ;
            S_READ:  n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        load_prod  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = smp_xfer;
            end
            S_READ:  load_prod = 1'b1;
            S_START: div_start = 1'b1;
            S_DIV:   out_load  = div_done && (!r_out_valid || !i_out_stall);
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // quotient magnitude fits below 2^48, sign applied afterwards
    always_comb begin
        q_ext    = RESULT_W'(quotient);
        q_signed = r_neg ? RESULT_W'(-q_ext) : q_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_scaled   <= r_span_zero ? '0 : $signed(q_signed);
            r_out_chan <= r_chan;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scaled_value = r_scaled;
    assign o_out_channel  = r_out_chan;
    assign o_frame_last   = r_out_last;

endmodule

// ===== rtl/msc_cal_mem.sv =====
// calibration table memory: one entry of ground and spans per channel
// depends on msc_pkg

module msc_cal_mem import msc_pkg::*; #(
    parameter int DEPTH = MAX_CHANNELS_DEF,
    parameter int AW    = 8
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  t_cal_entry      i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output t_cal_entry      o_rd_data
);

    t_cal_entry r_mem [DEPTH];
    t_cal_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/msc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on msc_pkg

module msc_div import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [SPAN_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [SPAN_W-1:0]     r_rem, n_rem;
    logic [SPAN_W-1:0]     r_den;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_done;

    logic [SPAN_W:0] rem_shift;
    logic [SPAN_W:0] rem_sub;
    logic            take;

    always_comb begin
        rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, r_den};
        take      = rem_shift >= {1'b0, r_den};
        n_rem     = take ? rem_sub[SPAN_W-1:0] : rem_shift[SPAN_W-1:0];
        n_quo     = {r_quo[DIVIDEND_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
